// File: rtl/core/sroe_pkg.sv
// Shared types and constants for the shift register output expander.
package sroe_pkg;

  localparam int MAX_PINS = 64;
  localparam int PIN_W    = $clog2(MAX_PINS);
  localparam int CNT_W    = 7;
  localparam int Q_DEPTH  = 2;
  localparam int QPTR_W   = $clog2(Q_DEPTH);
  localparam int QCNT_W   = $clog2(Q_DEPTH + 1);

  typedef enum logic [1:0] {
    OP_SET_PIN = 2'd0,
    OP_SET_ALL = 2'd1,
    OP_FLUSH   = 2'd2
  } opcode_t;

  typedef struct packed {
    logic [MAX_PINS-1:0] image;
    logic [CNT_W-1:0]    nbits;
  } flush_job_t;

  typedef struct packed {
    logic              full;
    logic              empty;
    logic [QCNT_W-1:0] count;
  } q_status_t;

endpackage

// File: rtl/core/sroe_front.sv
// Front end: accepts items, keeps the pin image and dirty flag, queues flush jobs.
module sroe_front import sroe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [CNT_W-1:0] pin_count,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic [PIN_W-1:0] in_pin_index,
  input  logic             in_pin_value,
  input  q_status_t        q_stat,
  output logic             q_push,
  output flush_job_t       q_job
);

  logic [MAX_PINS-1:0] image_r, image_nxt;
  logic                dirty_r, dirty_nxt;
  logic [CNT_W-1:0]    n_eff;
  logic [MAX_PINS-1:0] mask;
  logic                accept;

  assign n_eff = (pin_count > CNT_W'(MAX_PINS)) ? CNT_W'(MAX_PINS) : pin_count;
  assign mask  = (n_eff >= CNT_W'(MAX_PINS)) ? '1 :
                 ((MAX_PINS'(1) << n_eff) - MAX_PINS'(1));

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;
  assign q_job    = '{image: image_r, nbits: n_eff};

  always_comb begin
    image_nxt = image_r;
    dirty_nxt = dirty_r;
    q_push    = 1'b0;
    if (accept) begin
      unique case (opcode_t'(in_opcode))
        OP_SET_PIN: begin
          if (({1'b0, in_pin_index} < n_eff) && (image_r[in_pin_index] != in_pin_value)) begin
            image_nxt[in_pin_index] = in_pin_value;
            dirty_nxt = 1'b1;
          end
        end
        OP_SET_ALL: begin
          image_nxt = in_pin_value ? (image_r | mask) : (image_r & ~mask);
          dirty_nxt = 1'b1;
        end
        OP_FLUSH: begin
          if (dirty_r) begin
            dirty_nxt = 1'b0;
            q_push    = (n_eff != '0);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_r <= '0;
      dirty_r <= 1'b1;
    end else begin
      image_r <= image_nxt;
      dirty_r <= dirty_nxt;
    end
  end

endmodule

// File: rtl/core/sroe_queue.sv
// Short queue of pending flush jobs between front and back.
module sroe_queue import sroe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  flush_job_t job_in,
  input  logic       pop,
  output flush_job_t job_out,
  output q_status_t  stat
);

  flush_job_t          entry_r [Q_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r;
  logic [QPTR_W-1:0]   rd_ptr_r;
  logic [QCNT_W-1:0]   count_r;

  assign job_out    = entry_r[rd_ptr_r];
  assign stat.count = count_r;
  assign stat.full  = (count_r == QCNT_W'(Q_DEPTH));
  assign stat.empty = (count_r == '0);

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (pop && !push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

// File: rtl/core/sroe_back.sv
// Back end: shifts a queued flush job out one bit per item, highest pin first.
module sroe_back import sroe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  flush_job_t job,
  input  logic       q_empty,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_serial_bit,
  output logic       out_latch_now
);

  logic [MAX_PINS-1:0] img_r;
  logic [PIN_W-1:0]    pos_r;
  logic                busy_r;
  logic                out_valid_r;
  logic                out_bit_r;
  logic                out_latch_r;
  logic                out_free;
  logic [CNT_W-1:0]    last_pos;

  assign out_free       = !out_valid_r || !out_stall;
  assign q_pop          = !busy_r && !q_empty;
  assign last_pos       = job.nbits - CNT_W'(1);
  assign out_valid      = out_valid_r;
  assign out_serial_bit = out_bit_r;
  assign out_latch_now  = out_latch_r;

  always_ff @(posedge clk) begin
    if (q_pop) begin
      img_r <= job.image;
    end
    if (busy_r && out_free) begin
      out_bit_r   <= img_r[pos_r];
      out_latch_r <= (pos_r == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        pos_r  <= last_pos[PIN_W-1:0];
      end else if (busy_r && out_free) begin
        if (pos_r == '0) begin
          busy_r <= 1'b0;
        end else begin
          pos_r <= pos_r - 1'b1;
        end
      end
      if (out_free) begin
        out_valid_r <= busy_r;
      end
    end
  end

endmodule

// File: rtl/core/shift_register_output_expander.sv
// Top level of the shift register output expander: config register, front, queue, back.
// Set-pin and set-all items are accepted back to back while the job queue is not full.
// A flush with the dirty flag raised and a non-zero pin count snapshots the image into a
// two-entry job queue; the back end then emits one result per cycle while out_stall is
// low, pin_count results per flush (at most 64), highest pin first, with latch_now on
// pin 0. The first result of a flush passes from the job queue through the back end's
// image and output registers; an idle output gap parts consecutive flush jobs. The serial
// shifter sets the sustained rate during flushes: input stalls only while two flush jobs
// are waiting. The pin count is taken from the register when the flush is accepted.
// Reset takes effect at once; there is no clearing pass.
module shift_register_output_expander import sroe_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [1:0]       in_opcode,
  input  logic [PIN_W-1:0] in_pin_index,
  input  logic             in_pin_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             out_serial_bit,
  output logic             out_latch_now,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [CNT_W-1:0] cfg_pin_count
);

  logic [CNT_W-1:0] pin_count_r;
  q_status_t        q_stat;
  logic             q_push;
  logic             q_pop;
  flush_job_t       push_job;
  flush_job_t       head_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pin_count_r <= CNT_W'(MAX_PINS);
    end else if (cfg_valid && cfg_ready) begin
      pin_count_r <= cfg_pin_count;
    end
  end

  sroe_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .pin_count    (pin_count_r),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_opcode    (in_opcode),
    .in_pin_index (in_pin_index),
    .in_pin_value (in_pin_value),
    .q_stat       (q_stat),
    .q_push       (q_push),
    .q_job        (push_job)
  );

  sroe_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .job_in  (push_job),
    .pop     (q_pop),
    .job_out (head_job),
    .stat    (q_stat)
  );

  sroe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .job            (head_job),
    .q_empty        (q_stat.empty),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_serial_bit (out_serial_bit),
    .out_latch_now  (out_latch_now)
  );

  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= QCNT_W'(Q_DEPTH))
    else $error("job queue over depth");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("flush job pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("flush job popped from empty queue");

  a_job_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> (push_job.nbits != '0) && (push_job.nbits <= CNT_W'(MAX_PINS)))
    else $error("flush job with bad bit count");

endmodule

// File: sim/shift_register_output_expander_test.sv
// Self-checking testbench for the shift register output expander: directed table, then random phases.
module shift_register_output_expander_test;
  import sroe_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int         NO_TYPED  = -1;
  localparam int         LIMIT_CYCLES = 1000000;

  typedef struct packed {
    logic serial_bit;
    logic latch_now;
  } shift_bit_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t        kind;
    logic [CNT_W-1:0] cfg;
    logic [1:0]       op;
    logic [PIN_W-1:0] idx;
    logic             val;
    int               n;
    logic [63:0]      img;
  } row_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [1:0]       in_opcode = '0;
  logic [PIN_W-1:0] in_pin_index = '0;
  logic             in_pin_value = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic             out_serial_bit;
  logic             out_latch_now;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_pin_count = '0;

  // typed expectation travels with the item it belongs to
  int          typed_count = NO_TYPED;
  logic [63:0] typed_image = '0;

  logic [CNT_W-1:0] cur_pin_count = 7'd64;
  logic [63:0]      pin_image = '0;
  logic             dirty = 1'b1;
  shift_bit_t       exp_bits[$];

  int fail_count;
  int items_accepted;
  int bits_checked;
  int frames_seen;
  int settings_used;
  int burst_left;

  shift_register_output_expander u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_pin_index  (in_pin_index),
    .in_pin_value  (in_pin_value),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_serial_bit(out_serial_bit),
    .out_latch_now (out_latch_now),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_pin_count (cfg_pin_count)
  );

  always #4 clk = ~clk;

  function automatic int active_pins(logic [CNT_W-1:0] c);
    return (c > MAX_PINS) ? MAX_PINS : int'(c);
  endfunction

  function automatic void predict_item(logic [1:0] op, logic [PIN_W-1:0] idx, logic val,
                                       bit emit);
    int          n;
    logic [63:0] m;
    n = active_pins(cur_pin_count);
    m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
    case (op)
      OP_SET_PIN: begin
        if (int'(idx) < n && pin_image[idx] != val) begin
          pin_image[idx] = val;
          dirty = 1'b1;
        end
      end
      OP_SET_ALL: begin
        pin_image = val ? (pin_image | m) : (pin_image & ~m);
        dirty = 1'b1;
      end
      OP_FLUSH: begin
        if (dirty) begin
          if (emit) begin
            for (int p = n - 1; p >= 0; p--) begin
              exp_bits.push_back('{serial_bit: pin_image[p], latch_now: (p == 0)});
            end
          end
          dirty = 1'b0;
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    shift_bit_t e;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        cur_pin_count = cfg_pin_count;
      end
      if (in_valid && !in_stall) begin
        items_accepted++;
        predict_item(in_opcode, in_pin_index, in_pin_value, typed_count == NO_TYPED);
        for (int p = typed_count - 1; p >= 0; p--) begin
          exp_bits.push_back('{serial_bit: typed_image[p], latch_now: (p == 0)});
        end
      end
      if (out_valid && !out_stall) begin
        if (exp_bits.size() == 0) begin
          $error("unexpected result: serial_bit %0b latch_now %0b",
                 out_serial_bit, out_latch_now);
          fail_count++;
        end else begin
          e = exp_bits.pop_front();
          bits_checked++;
          if (out_latch_now) frames_seen++;
          if (out_serial_bit !== e.serial_bit) begin
            $error("serial_bit: expected %0b, got %0b", e.serial_bit, out_serial_bit);
            fail_count++;
          end
          if (out_latch_now !== e.latch_now) begin
            $error("latch_now: expected %0b, got %0b", e.latch_now, out_latch_now);
            fail_count++;
          end
        end
      end
    end
  end

  // receiver stall pattern: free run, random, periodic, heavy
  int stall_mode;
  int stall_left;
  int stall_tick;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end else begin
      stall_left--;
    end
    stall_tick++;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= ($urandom_range(0, 99) < 30);
      2: out_stall <= (stall_tick % 3 == 0);
      default: out_stall <= (stall_tick % 7 < 5);
    endcase
  end

  task automatic send_item(logic [1:0] op, logic [PIN_W-1:0] idx, logic val, int tn,
                           logic [63:0] timg);
    in_valid     <= 1'b1;
    in_opcode    <= op;
    in_pin_index <= idx;
    in_pin_value <= val;
    typed_count  <= tn;
    typed_image  <= timg;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic maybe_gap();
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 15);
    end else begin
      burst_left--;
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_bits.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_pin_count(logic [CNT_W-1:0] v);
    wait_drained();
    cfg_valid     <= 1'b1;
    cfg_pin_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    #(LIMIT_CYCLES * 8);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  row_t directed_rows [27];

  initial begin
    int               n;
    int               items_in_phase;
    int               r;
    logic [1:0]       op;
    logic [PIN_W-1:0] idx;
    logic [CNT_W-1:0] cnt;

    directed_rows = '{
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd0,  1'b0, 64, 64'h0},
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd0,  1'b1, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_SET_PIN, 6'd63, 1'b1, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_SET_PIN, 6'd0,  1'b1, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd63, 1'b0, 64, 64'h8000_0000_0000_0001},
      '{ROW_ITEM, 7'd0,   OP_SET_PIN, 6'd0,  1'b1, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd0,  1'b0, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_SET_ALL, 6'd21, 1'b1, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd0,  1'b0, 64, '1},
      '{ROW_ITEM, 7'd0,   OP_SET_ALL, 6'd0,  1'b1, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd0,  1'b0, 64, '1},
      '{ROW_ITEM, 7'd0,   OP_UNUSED,  6'd63, 1'b1, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd0,  1'b0, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_SET_ALL, 6'd0,  1'b0, NO_TYPED, 64'h0},
      '{ROW_ITEM, 7'd0,   OP_SET_PIN, 6'd42, 1'b1, NO_TYPED, 64'h0},
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd0,  1'b0, NO_TYPED, 64'h0},
      '{ROW_CFG,  7'd1,   OP_FLUSH,   6'd0,  1'b0, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_SET_PIN, 6'd1,  1'b1, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_SET_PIN, 6'd0,  1'b1, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd0,  1'b0, 1,  64'h1},
      '{ROW_CFG,  7'd0,   OP_FLUSH,   6'd0,  1'b0, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_SET_ALL, 6'd0,  1'b1, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd0,  1'b0, 0,  64'h0},
      '{ROW_CFG,  7'd8,   OP_FLUSH,   6'd0,  1'b0, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_SET_ALL, 6'd0,  1'b1, NO_TYPED, 64'h0},
      '{ROW_CFG,  7'd127, OP_FLUSH,   6'd0,  1'b0, 0,  64'h0},
      '{ROW_ITEM, 7'd0,   OP_FLUSH,   6'd0,  1'b0, NO_TYPED, 64'h0}
    };

    burst_left = 10;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_pin_count(directed_rows[i].cfg);
      end else begin
        maybe_gap();
        send_item(directed_rows[i].op, directed_rows[i].idx, directed_rows[i].val,
                  directed_rows[i].n, directed_rows[i].img);
      end
    end
    // count just above the maximum, top pin changed
    write_pin_count(7'd65);
    send_item(OP_SET_PIN, 6'd63, 1'b1, NO_TYPED, '0);
    send_item(OP_FLUSH, 6'd0, 1'b0, NO_TYPED, '0);

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: cnt = 7'd64;
        1: cnt = CNT_W'($urandom_range(1, 63));
        2: cnt = 7'd127;
        3: cnt = CNT_W'($urandom_range(1, 16));
        4: cnt = 7'd0;
        5: cnt = CNT_W'($urandom_range(65, 126));
        default: cnt = 7'd8;
      endcase
      write_pin_count(cnt);
      n = active_pins(cnt);
      items_in_phase = (ph == 4) ? 20 : 75;
      for (int k = 0; k < items_in_phase; k++) begin
        if (ph == 1 && k == 40) wait_drained();
        maybe_gap();
        r = $urandom_range(0, 99);
        if (r < 45)      op = OP_SET_PIN;
        else if (r < 55) op = OP_SET_ALL;
        else if (r < 88) op = OP_FLUSH;
        else             op = OP_UNUSED;
        if (n > 0 && $urandom_range(0, 9) < 7) idx = PIN_W'($urandom_range(0, n - 1));
        else                                   idx = PIN_W'($urandom_range(0, 63));
        send_item(op, idx, 1'($urandom_range(0, 1)), NO_TYPED, '0);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (exp_bits.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d items over %0d pin count settings: %0d bits shifted, %0d latched frames",
             items_accepted, settings_used, bits_checked, frames_seen);
    if (fail_count == 0 && exp_bits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
